FILE: hw/rtl/uts_pkg.sv
// uts_pkg: shared types, constants and byte classification for the utf-8 text sanitizer
// no dependencies; compiled before the interfaces and all modules
`default_nettype none

package uts_pkg;

    typedef logic [7:0] byte_t;

    // result entry as it leaves the block
    typedef struct packed {
        byte_t out_byte;
        logic  byte_present;
        logic  out_last;
    } res_t;

    // bytes of an open sequence that wait for their continuation bytes
    localparam int HELD_DEPTH  = 3;
    localparam int HELD_CNT_W  = $clog2(HELD_DEPTH + 1);

    // length code of an open sequence, zero when none is pending
    localparam int SEQ_LEN_W   = 3;
    localparam logic [SEQ_LEN_W-1:0] SEQ_NONE  = 3'd0;
    localparam logic [SEQ_LEN_W-1:0] SEQ_TWO   = 3'd2;
    localparam logic [SEQ_LEN_W-1:0] SEQ_THREE = 3'd3;
    localparam logic [SEQ_LEN_W-1:0] SEQ_FOUR  = 3'd4;

    // one accepted byte releases at most this many results
    localparam int MAX_BURST   = 4;
    localparam int BURST_LEN_W = $clog2(MAX_BURST + 1);

    // result queue
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int FILL_W      = PTR_W + 1;

    localparam byte_t CONT_MASK    = 8'hC0;
    localparam byte_t CONT_PATTERN = 8'h80;
    localparam byte_t PRINT_LO     = 8'd32;
    localparam byte_t PRINT_HI     = 8'd126;
    localparam byte_t CHAR_TAB     = 8'd9;
    localparam byte_t CHAR_LF      = 8'd10;
    localparam byte_t CHAR_CR      = 8'd13;
    localparam byte_t LEAD2_LO     = 8'd192;
    localparam byte_t LEAD2_HI     = 8'd223;
    localparam byte_t LEAD3_LO     = 8'd224;
    localparam byte_t LEAD3_HI     = 8'd239;
    localparam byte_t LEAD4_LO     = 8'd240;
    localparam byte_t LEAD4_HI     = 8'd247;

    // printable ascii or one of tab, lf, cr
    function automatic logic is_plain_char(input byte_t b);
        return ((b >= PRINT_LO) && (b <= PRINT_HI)) ||
               (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR);
    endfunction

    function automatic logic is_cont_byte(input byte_t b);
        return (b & CONT_MASK) == CONT_PATTERN;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/uts_raw_if.sv
// uts_raw_if: valid/ready channel carrying raw text bytes into the sanitizer
// depends on uts_pkg
`default_nettype none

interface uts_raw_if
    import uts_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t in_byte;
    logic  in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/uts_clean_if.sv
// uts_clean_if: valid/ready channel carrying cleaned text results out of the sanitizer
// depends on uts_pkg
`default_nettype none

interface uts_clean_if
    import uts_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  byte_present;
    logic  out_last;

    modport source (output valid, output out_byte, output byte_present, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_present, input out_last,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/utf8_text_sanitizer_unit.sv
// utf8_text_sanitizer_unit: streaming utf-8 validating text filter, one byte per transfer
// depends on uts_pkg, uts_raw_if and uts_clean_if
//
// The block takes one raw byte per transfer on raw and delivers the cleaned text on clean.
// Printable ascii, tab, lf and cr pass straight through; a lead byte 0xC0-0xDF, 0xE0-0xEF
// or 0xF0-0xF7 is held with its continuation bytes until the sequence is complete, then
// the whole sequence is released in order. Anything else is dropped, a non-continuation
// byte cancels an open sequence, and an open sequence at in_last is discarded. The final
// result of each text has out_last set; when nothing is left to send for the final byte,
// an empty marker (byte_present low, out_byte zero) carries the flag. Rate: one byte is
// accepted every cycle while raw.ready is high; each result is registered into an 8-entry
// queue and shows on clean once the results ahead of it are taken. The queue drains one result
// per cycle while clean.ready is high; raw.ready is low only while it holds more than 4 results.
`default_nettype none

module utf8_text_sanitizer_unit
    import uts_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    uts_raw_if.sink     raw,
    uts_clean_if.source clean
);

    // open sequence state
    byte_t                  held_reg  [HELD_DEPTH];
    byte_t                  held_next [HELD_DEPTH];
    logic [HELD_CNT_W-1:0]  held_cnt_reg, held_cnt_next;
    logic [SEQ_LEN_W-1:0]   seq_len_reg, seq_len_next;

    // result queue
    res_t                   fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;

    // results released by the current byte
    res_t                   burst [MAX_BURST];
    logic [BURST_LEN_W-1:0] burst_len;
    logic [BURST_LEN_W-1:0] push_len;

    logic  accept;
    logic  pop;
    logic  pending;
    logic  is_cont;
    logic  complete;
    logic  extend;
    byte_t b;

    assign b       = raw.in_byte;
    assign accept  = raw.valid && raw.ready;
    assign pop     = clean.valid && clean.ready;
    assign pending = (seq_len_reg != SEQ_NONE);
    assign is_cont = is_cont_byte(b);

    // the continuation byte that closes the open sequence
    assign complete = pending && is_cont &&
                      ((SEQ_LEN_W'(held_cnt_reg) + SEQ_LEN_W'(1)) >= seq_len_reg);
    // a continuation byte that still leaves the sequence open
    assign extend   = pending && is_cont && !complete;

    // classify the byte, update the open sequence and build the result burst
    always_comb
    begin
        held_next     = held_reg;
        held_cnt_next = held_cnt_reg;
        seq_len_next  = seq_len_reg;
        burst_len     = '0;
        for (int k = 0; k < MAX_BURST; k++)
        begin
            burst[k] = '0;
        end

        if (complete)
        begin
            // held bytes first (at least the lead byte), then the closing byte
            burst[0].out_byte = held_reg[0];
            burst[1].out_byte = (held_cnt_reg > HELD_CNT_W'(1)) ? held_reg[1] : b;
            burst[2].out_byte = (held_cnt_reg > HELD_CNT_W'(2)) ? held_reg[2] : b;
            burst[3].out_byte = b;
            for (int k = 0; k < MAX_BURST; k++)
            begin
                burst[k].byte_present = 1'b1;
            end
            burst_len     = BURST_LEN_W'(held_cnt_reg) + BURST_LEN_W'(1);
            held_cnt_next = '0;
            seq_len_next  = SEQ_NONE;
        end
        else if (extend)
        begin
            // never full here: an open sequence holds at most three bytes before closing
            held_next[held_cnt_reg] = b;
            held_cnt_next           = held_cnt_reg + HELD_CNT_W'(1);
        end
        else
        begin
            // fresh judgement; any open sequence is dropped
            held_cnt_next = '0;
            seq_len_next  = SEQ_NONE;
            if (!b[7])
            begin
                if (is_plain_char(b))
                begin
                    burst[0].out_byte     = b;
                    burst[0].byte_present = 1'b1;
                    burst_len             = BURST_LEN_W'(1);
                end
            end
            else if ((b >= LEAD2_LO) && (b <= LEAD2_HI))
            begin
                held_next[0]  = b;
                held_cnt_next = HELD_CNT_W'(1);
                seq_len_next  = SEQ_TWO;
            end
            else if ((b >= LEAD3_LO) && (b <= LEAD3_HI))
            begin
                held_next[0]  = b;
                held_cnt_next = HELD_CNT_W'(1);
                seq_len_next  = SEQ_THREE;
            end
            else if ((b >= LEAD4_LO) && (b <= LEAD4_HI))
            begin
                held_next[0]  = b;
                held_cnt_next = HELD_CNT_W'(1);
                seq_len_next  = SEQ_FOUR;
            end
        end

        // end of text: discard any open sequence, flag the final result
        if (raw.in_last)
        begin
            held_cnt_next = '0;
            seq_len_next  = SEQ_NONE;
            if (burst_len == '0)
            begin
                // empty end marker
                burst[0]  = '0;
                burst_len = BURST_LEN_W'(1);
            end
            for (int k = 0; k < MAX_BURST; k++)
            begin
                if (BURST_LEN_W'(k) == (burst_len - BURST_LEN_W'(1)))
                begin
                    burst[k].out_last = 1'b1;
                end
            end
        end
    end

    // queue pointers and fill level
    assign push_len = accept ? burst_len : '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_len);
        rd_ptr_next = pop ? (rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        fill_next   = fill_reg + FILL_W'(push_len) - FILL_W'(pop);
    end

    // room for a full burst is kept free whenever a byte is taken
    assign raw.ready          = (fill_reg <= FILL_W'(FIFO_DEPTH - MAX_BURST));
    assign clean.valid        = (fill_reg != '0);
    assign clean.out_byte     = fifo_reg[rd_ptr_reg].out_byte;
    assign clean.byte_present = fifo_reg[rd_ptr_reg].byte_present;
    assign clean.out_last     = fifo_reg[rd_ptr_reg].out_last;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= '0;
            seq_len_reg  <= SEQ_NONE;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                held_cnt_reg <= held_cnt_next;
                seq_len_reg  <= seq_len_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // payload storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < HELD_DEPTH; i++)
            begin
                held_reg[i] <= held_next[i];
            end
            for (int k = 0; k < MAX_BURST; k++)
            begin
                if (BURST_LEN_W'(k) < burst_len)
                begin
                    fifo_reg[wr_ptr_reg + PTR_W'(k)] <= burst[k];
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/uts_checker.sv
// uts_checker: port-level assertions for utf8_text_sanitizer_unit, bound to the top level
// depends on uts_pkg and utf8_text_sanitizer_unit
`default_nettype none

module uts_checker
    import uts_pkg::*;
(
    input wire       clk,
    input wire       rst_n,
    input wire       raw_valid,
    input wire       raw_ready,
    input wire [7:0] raw_byte,
    input wire       raw_last,
    input wire       clean_valid,
    input wire       clean_ready,
    input wire [7:0] clean_byte,
    input wire       clean_present,
    input wire       clean_last
);

    wire raw_xfer = raw_valid && raw_ready;

    // stalled result holds until taken
    a_clean_hold: assert property (@(posedge clk) disable iff (!rst_n)
        clean_valid && !clean_ready |=>
            clean_valid && $stable(clean_byte) && $stable(clean_present) &&
            $stable(clean_last))
        else $error("stalled result changed");

    // an empty marker only ever ends a text and carries a zero byte
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        clean_valid && !clean_present |-> clean_last && (clean_byte == 8'h00))
        else $error("malformed empty marker");

    // the final byte of a text always yields a result on the next cycle
    a_last_yields: assert property (@(posedge clk) disable iff (!rst_n)
        raw_xfer && raw_last |=> clean_valid)
        else $error("no result after end of text");

    // a plain ascii byte always yields a result on the next cycle
    a_plain_yields: assert property (@(posedge clk) disable iff (!rst_n)
        raw_xfer && is_plain_char(raw_byte) |=> clean_valid)
        else $error("plain byte lost");

endmodule

bind utf8_text_sanitizer_unit uts_checker u_uts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .raw_valid     (raw.valid),
    .raw_ready     (raw.ready),
    .raw_byte      (raw.in_byte),
    .raw_last      (raw.in_last),
    .clean_valid   (clean.valid),
    .clean_ready   (clean.ready),
    .clean_byte    (clean.out_byte),
    .clean_present (clean.byte_present),
    .clean_last    (clean.out_last)
);

`default_nettype wire

FILE: tb/uts_text_checker.sv
`timescale 1ns / 1ps
// uts_text_checker: watches the raw and clean channels of the utf-8 text sanitizer,
// predicts the cleaned text and compares it result by result
// depends on uts_pkg, uts_raw_if and uts_clean_if
module uts_text_checker
    import uts_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    uts_raw_if   raw,
    uts_clean_if clean,
    output int   fail_count,
    output int   results_owed
);

    // open sequence as the checker sees it
    byte_t                 open_bytes [HELD_DEPTH];
    logic [HELD_CNT_W-1:0] open_cnt;
    logic [SEQ_LEN_W-1:0]  open_len;

    res_t clean_owed_q [$];
    res_t want;
    int   fails = 0;

    function automatic res_t kept_byte(input byte_t b);
        kept_byte = '{out_byte: b, byte_present: 1'b1, out_last: 1'b0};
    endfunction

    task automatic predict_clean_text(input byte_t b, input logic last);
        res_t outs [MAX_BURST];
        int   n;
        n = 0;
        if (open_len != SEQ_NONE && (b & CONT_MASK) == CONT_PATTERN)
        begin
            if (int'(open_cnt) + 1 >= int'(open_len))
            begin
                // sequence complete, release held bytes then this one
                for (int i = 0; i < int'(open_cnt); i++)
                begin
                    outs[n] = kept_byte(open_bytes[i]);
                    n++;
                end
                outs[n] = kept_byte(b);
                n++;
                open_cnt = '0;
                open_len = SEQ_NONE;
            end
            else if (int'(open_cnt) < HELD_DEPTH)
            begin
                open_bytes[open_cnt] = b;
                open_cnt             = open_cnt + 1'b1;
            end
            else
            begin
                open_cnt = '0;
                open_len = SEQ_NONE;
            end
        end
        else
        begin
            open_cnt = '0;
            open_len = SEQ_NONE;
            if (!b[7])
            begin
                if ((b >= PRINT_LO && b <= PRINT_HI) ||
                    b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR)
                begin
                    outs[n] = kept_byte(b);
                    n++;
                end
            end
            else if (b >= LEAD2_LO && b <= LEAD2_HI)
            begin
                open_bytes[0] = b;
                open_cnt      = HELD_CNT_W'(1);
                open_len      = SEQ_TWO;
            end
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
            begin
                open_bytes[0] = b;
                open_cnt      = HELD_CNT_W'(1);
                open_len      = SEQ_THREE;
            end
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
            begin
                open_bytes[0] = b;
                open_cnt      = HELD_CNT_W'(1);
                open_len      = SEQ_FOUR;
            end
        end
        if (last)
        begin
            open_cnt = '0;
            open_len = SEQ_NONE;
            if (n == 0)
            begin
                outs[0] = '{out_byte: 8'h00, byte_present: 1'b0, out_last: 1'b0};
                n       = 1;
            end
            outs[n-1].out_last = 1'b1;
        end
        for (int i = 0; i < n; i++)
            clean_owed_q.insert(clean_owed_q.size(), outs[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_cnt = '0;
            open_len = SEQ_NONE;
            clean_owed_q.delete();
            fail_count   <= 0;
            results_owed <= 0;
        end
        else
        begin
            if (raw.valid && raw.ready)
                predict_clean_text(raw.in_byte, raw.in_last);
            if (clean.valid && clean.ready)
            begin
                if (clean_owed_q.size() == 0)
                begin
                    $display("%0t: unexpected result byte=%02h present=%0b last=%0b",
                             $time, clean.out_byte, clean.byte_present, clean.out_last);
                    fails++;
                end
                else
                begin
                    want = clean_owed_q.pop_front();
                    if (clean.out_byte !== want.out_byte ||
                        clean.byte_present !== want.byte_present ||
                        clean.out_last !== want.out_last)
                    begin
                        $display("%0t: mismatch expected byte=%02h present=%0b last=%0b, %s",
                                 $time, want.out_byte, want.byte_present, want.out_last,
                                 $sformatf("actual byte=%02h present=%0b last=%0b",
                                           clean.out_byte, clean.byte_present,
                                           clean.out_last));
                        fails++;
                    end
                end
            end
            fail_count   <= fails;
            results_owed <= clean_owed_q.size();
        end
    end

endmodule

FILE: tb/tb_utf8_text_sanitizer_unit.sv
`timescale 1ns / 1ps
// tb_utf8_text_sanitizer_unit: drives raw text into the sanitizer and stalls its output
// depends on uts_pkg, uts_raw_if, uts_clean_if, utf8_text_sanitizer_unit, uts_text_checker
module tb_utf8_text_sanitizer_unit;
    import uts_pkg::*;

    // receiver stall patterns
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_LONG
    } rx_mode_e;

    localparam int RANDOM_ITEMS = 220;
    localparam int DRAIN_LIMIT  = 5000;

    // directed text: {in_last, in_byte}
    localparam logic [8:0] DIRECTED [29] = '{
        9'h020, 9'h07E, 9'h009, 9'h00A, 9'h00D,   // printable edges, tab, lf, cr
        9'h07F, 9'h000, 9'h01F,                   // del and control bytes dropped
        9'h0C0, 9'h080,                           // lowest 2-byte lead, overlong passes
        9'h0DF, 9'h0BF,                           // highest 2-byte form
        9'h080,                                   // stray continuation dropped
        9'h0EF, 9'h0BF, 9'h0BF,                   // highest 3-byte form
        9'h0F7, 9'h080, 9'h080, 9'h0BF,           // 4-byte burst of four results
        9'h0C3, 9'h041,                           // non-continuation cancels, judged afresh
        9'h0E2, 9'h082, 9'h0F8,                   // 0xf8 drops pending and itself
        9'h0F0, 9'h090, 9'h17E,                   // cancel then last with output
        9'h1E0                                    // open lead at end: empty marker
    };

    logic clk;
    logic rst_n;

    uts_raw_if   raw_ch ();
    uts_clean_if clean_ch ();

    int    fail_count;
    int    results_owed;
    int    burst_left = 0;
    int    random_items = 0;
    byte_t text_q [$];

    utf8_text_sanitizer_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_ch),
        .clean (clean_ch)
    );

    uts_text_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .raw          (raw_ch),
        .clean        (clean_ch),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #2_000_000;
        $display("FAIL utf8_text_sanitizer_unit");
        $finish;
    end

    // receiver: switches at random between stall patterns
    initial
    begin : rx_stall
        rx_mode_e mode;
        int       mode_left;
        mode           = RX_ALWAYS;
        mode_left      = 0;
        clean_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
                RX_ALWAYS:   clean_ch.ready <= 1'b1;
                RX_RANDOM:   clean_ch.ready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: clean_ch.ready <= (mode_left % 4) != 0;
                default:     clean_ch.ready <= (mode_left % 24) >= 16;
            endcase
        end
    end

    // one transfer on raw; the sender idles between bursts of random length,
    // and now and then a long burst runs with no gap at all
    task automatic send_byte(input byte_t b, input logic last);
        if (burst_left == 0)
        begin
            raw_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
        end
        raw_ch.valid   <= 1'b1;
        raw_ch.in_byte <= b;
        raw_ch.in_last <= last;
        @(posedge clk);
        while (!raw_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    // appends one byte to the text being built
    function automatic void queue_byte(input byte_t b);
        text_q = {text_q, b};
    endfunction

    // appends one random chunk of text: mostly well-formed characters,
    // with cut-off sequences, stray continuations and arbitrary noise mixed in
    task automatic add_text_chunk();
        int    pick;
        int    seq_len;
        int    keep;
        byte_t lead;
        pick = $urandom_range(0, 19);
        if (pick < 9)
        begin
            queue_byte(byte_t'($urandom_range(32, 126)));
        end
        else if (pick == 9)
        begin
            case ($urandom_range(0, 2))
                0:       queue_byte(CHAR_TAB);
                1:       queue_byte(CHAR_LF);
                default: queue_byte(CHAR_CR);
            endcase
        end
        else if (pick < 17)
        begin
            seq_len = $urandom_range(2, 4);
            case (seq_len)
                2:       lead = byte_t'($urandom_range(LEAD2_LO, LEAD2_HI));
                3:       lead = byte_t'($urandom_range(LEAD3_LO, LEAD3_HI));
                default: lead = byte_t'($urandom_range(LEAD4_LO, LEAD4_HI));
            endcase
            // a cut-off sequence keeps fewer continuation bytes
            keep = (pick == 16) ? $urandom_range(0, seq_len - 2) : seq_len - 1;
            queue_byte(lead);
            repeat (keep)
                queue_byte({2'b10, 6'($urandom)});
        end
        else if (pick == 17)
        begin
            queue_byte(($urandom_range(0, 1) == 1) ? byte_t'($urandom_range(248, 255))
                                                   : {2'b10, 6'($urandom)});
        end
        else
        begin
            queue_byte(byte_t'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin : stimulus
        int chunks;
        int waited;
        rst_n          = 1'b0;
        raw_ch.valid   = 1'b0;
        raw_ch.in_byte = '0;
        raw_ch.in_last = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: byte-class edges and each special case
        foreach (DIRECTED[i])
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        // random texts, mostly short, each closed by in_last on its final byte
        while (random_items < RANDOM_ITEMS)
        begin
            text_q.delete();
            chunks = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 14);
            repeat (chunks)
                add_text_chunk();
            foreach (text_q[i])
                send_byte(text_q[i], i == text_q.size() - 1);
            random_items += text_q.size();
        end
        raw_ch.valid <= 1'b0;

        // let the output queue drain, then wait on for anything spurious
        waited = 0;
        while (results_owed != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        if (results_owed != 0)
            $display("%0t: %0d expected results never arrived", $time, results_owed);
        if (fail_count == 0 && results_owed == 0)
            $display("PASS utf8_text_sanitizer_unit");
        else
            $display("FAIL utf8_text_sanitizer_unit");
        $finish;
    end

endmodule
